FILE: hw/rtl/hcsa_pkg.sv
// Package: constants and types for the hash chain saturating accumulator.
`default_nettype none
package hcsa_pkg;
    localparam int Buckets = 256;
    localparam int Nodes   = 4096;
    localparam int BW = $clog2(Buckets);
    localparam int NW = $clog2(Nodes);
    localparam int CW = $clog2(Nodes + 1);

    typedef logic [63:0] key_t;
    typedef logic [31:0] value_t;
    typedef logic [NW-1:0] node_idx_t;
    typedef logic [BW-1:0] bucket_t;

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    localparam value_t ValueMax = '1;

    // xor fold of the key down to a bucket index
    function automatic bucket_t bucket_of(input key_t key);
        logic [31:0] f;
        f = key[31:0] ^ key[63:32];
        f = f ^ {16'd0, f[31:16]};
        return f[BW-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/hash_chain_saturating_accumulate.sv
// Top level: hashed chain walk with saturating accumulate over on-chip memories.
//
//  channel | ports                        | direction
//  s_      | s_key, s_amount              | input beat
//  m_      | m_status, m_total, m_saturated| result beat
//
// A beat passes through idle, the bucket head read, a check of the head that
// issues its node read, the S_CMP state for each chain node compared, a write
// back and the output register, where it stays until m_ready is seen.
// Reset clears the bucket heads by a sweep over all 256 buckets; no beat is taken then.
// The result sits in an output register; a stall on m_ holds the next item off.
`default_nettype none
module hash_chain_saturating_accumulate
    import hcsa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [63:0] s_key,
    input  wire logic [31:0] s_amount,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_total,
    output logic             m_saturated,
    output logic             m_valid,
    input  wire logic        m_ready
);
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HEAD  = 7'b0000100,
        S_NODE  = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // memories
    node_idx_t heads_mem [Buckets];
    key_t      keys_mem  [Nodes];
    value_t    vals_mem  [Nodes];
    node_idx_t links_mem [Nodes];

    node_idx_t head_rd;
    key_t      key_rd;
    value_t    val_rd;
    node_idx_t link_rd;

    key_t          key_reg;
    value_t        amt_reg;
    bucket_t       bkt_reg;
    node_idx_t     idx_reg;
    node_idx_t     head_reg;
    logic [CW-1:0] used_reg;
    bucket_t       clr_reg;
    logic [1:0]    st_reg;
    value_t        tot_reg;
    logic          sat_reg;
    logic          ins_reg;
    logic          upd_reg;

    logic          hd_we, nd_we, vl_we;
    bucket_t       hd_waddr;
    node_idx_t     hd_wdata;
    node_idx_t     nd_rdaddr;
    node_idx_t     new_idx;
    logic [32:0]   sum;
    logic          chain_ok;

    assign new_idx   = used_reg[NW-1:0];
    assign sum       = {1'b0, val_rd} + {1'b0, amt_reg};
    assign chain_ok  = (link_rd != '0) && ({1'b0, link_rd} < used_reg);
    assign nd_rdaddr = (state_reg == S_NODE) ? head_rd : link_rd;

    // write enables: bucket heads (clear sweep, or link a new node), node key and link, value
    always_comb begin
        hd_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE && ins_reg);
        hd_waddr = (state_reg == S_CLEAR) ? clr_reg : bkt_reg;
        hd_wdata = (state_reg == S_CLEAR) ? '0 : new_idx;
        nd_we    = (state_reg == S_WRITE) && ins_reg;
        vl_we    = (state_reg == S_WRITE) && (ins_reg || upd_reg);
    end

    always_ff @(posedge aclk) begin
        if (hd_we) begin
            heads_mem[hd_waddr] <= hd_wdata;
        end
        head_rd <= heads_mem[bkt_reg];
    end

    always_ff @(posedge aclk) begin
        if (nd_we) begin
            keys_mem[new_idx]  <= key_reg;
            links_mem[new_idx] <= head_reg;
        end
        if (vl_we) begin
            vals_mem[ins_reg ? new_idx : idx_reg] <= tot_reg;
        end
        key_rd  <= keys_mem[nd_rdaddr];
        val_rd  <= vals_mem[nd_rdaddr];
        link_rd <= links_mem[nd_rdaddr];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == bucket_t'(Buckets - 1)) state_next = S_IDLE;
            S_IDLE:  if (s_valid) state_next = S_HEAD;
            S_HEAD:  state_next = S_NODE;
            S_NODE: begin
                // head_rd valid here; its node read is always issued, but used only when the chain is nonempty
                if (head_rd == '0 || {1'b0, head_rd} >= used_reg) state_next = S_WRITE;
                else state_next = S_CMP;
            end
            S_CMP: begin
                if (key_rd == key_reg || !chain_ok) state_next = S_WRITE;
            end
            S_WRITE: state_next = S_OUT;
            S_OUT:   if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            used_reg  <= CW'(1);
            ins_reg   <= 1'b0;
            upd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + bucket_t'(1);
            end
            if (state_reg == S_IDLE && s_valid) begin
                key_reg <= s_key;
                amt_reg <= s_amount;
                bkt_reg <= bucket_of(s_key);
                ins_reg <= 1'b0;
                upd_reg <= 1'b0;
            end
            if (state_reg == S_NODE) begin
                head_reg <= head_rd;
                idx_reg  <= head_rd;
            end
            // decide the outcome when the walk ends, with or without a match; else step to the next node
            if ((state_reg == S_NODE &&
                 (head_rd == '0 || {1'b0, head_rd} >= used_reg)) ||
                (state_reg == S_CMP && key_rd != key_reg && !chain_ok)) begin
                if (used_reg >= CW'(Nodes)) begin
                    st_reg  <= ST_FULL;
                    tot_reg <= '0;
                end else begin
                    st_reg  <= ST_INSERTED;
                    tot_reg <= amt_reg;
                    ins_reg <= 1'b1;
                end
                sat_reg <= 1'b0;
            end else if (state_reg == S_CMP) begin
                if (key_rd == key_reg) begin
                    st_reg  <= ST_UPDATED;
                    tot_reg <= sum[32] ? ValueMax : sum[31:0];
                    sat_reg <= sum[32];
                    upd_reg <= 1'b1;
                end else begin
                    idx_reg <= link_rd;
                end
            end
            if (state_reg == S_WRITE && ins_reg) begin
                used_reg <= used_reg + CW'(1);
            end
        end
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = (state_reg == S_OUT);
    assign m_status    = st_reg;
    assign m_total     = tot_reg;
    assign m_saturated = sat_reg;
endmodule
`default_nettype wire
